[hdl/ptl_pkg.sv]
`default_nettype none
package ptl_pkg;

  typedef enum logic [1:0] {
    FUNC_HANDSHAKE = 2'd0,
    FUNC_DATA      = 2'd1,
    FUNC_TICK      = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    EV_HS_OK     = 3'd0,
    EV_FULL      = 3'd1,
    EV_DATA_OK   = 3'd2,
    EV_UNKNOWN   = 3'd3,
    EV_TICK_ACT  = 3'd4,
    EV_TICK_DONE = 3'd5
  } event_e;

  localparam logic [1:0] REG_HB_ENABLE   = 2'd0;
  localparam logic [1:0] REG_HB_INTERVAL = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] peer_mac;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [3:0]  granted_id;
    logic        id_available;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [3:0]  slot;
    logic [3:0]  tracker_id;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic        send_heartbeat;
    logic [63:0] heartbeat_seq;
    logic        went_online;
    logic        went_offline;
    logic        is_new;
    logic        last;
  } out_word_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [3:0]  tracker_id;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] last_hb;
    logic [31:0] last_seen;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // signed elapsed time reached the limit
  function automatic logic reached(input logic [31:0] now, input logic [31:0] then_t,
                                   input logic [15:0] limit);
    logic [31:0] diff;
    diff = now - then_t;
    return !diff[31] && (diff >= {16'd0, limit});
  endfunction

endpackage
`default_nettype wire

[hdl/ptl_mem.sv]
`default_nettype none
module ptl_mem
  import ptl_pkg::*;
#(
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic [Aw-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem_q [Depth];

  // one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[hdl/peer_table_with_liveness.sv]
`default_nettype none
// A handshake or data word that finds its slot passes scan, decide, read and update; a new
// entry passes scan, decide and update; table full or unknown source pass scan, decide, out.
// A tick checks one slot per cycle while no output stall holds a parked word; each action
// word leaves once the next action is found, and its final word leaves from the out state.
// One word at a time: input is stalled until the block is idle again. Output stalls add waits.
// Reset: valid/online flags, sequence counter and control clear at once; registers go to
// enable 1, interval 1000, timeout 5000. No clearing pass.
module peer_table_with_liveness
  import ptl_pkg::*;
#(
  parameter int unsigned MAX_PEERS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned Aw = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned Cw = $clog2(MAX_PEERS + 1);

  state_e state_q, state_d;
  in_word_t  req_q;
  out_word_t res_q, res_d;
  logic          res_valid_q, res_valid_d;
  logic [MAX_PEERS-1:0] used_q, used_d, conn_q, conn_d;
  logic [63:0] seq_q, seq_d;
  logic [Cw-1:0] cnt_q, cnt_d;      // scan position, one past the slot being checked
  logic [Aw-1:0] hit_q, hit_d, free_q, free_d;
  logic hit_ok_q, hit_ok_d, free_ok_q, free_ok_d;
  logic          hb_en_q;
  logic [15:0]   hb_int_q, tmo_q;

  // parked tick action word, released when a later one is found or at walk end
  out_word_t pend_q, pend_d;
  logic      pend_valid_q, pend_valid_d;

  logic          mem_we;
  logic [Aw-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  ptl_mem #(.Depth(MAX_PEERS)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_en_q  <= 1'b1;
      hb_int_q <= 16'd1000;
      tmo_q    <= 16'd5000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HB_ENABLE:   hb_en_q  <= cfg_data_i[0];
        REG_HB_INTERVAL: hb_int_q <= cfg_data_i;
        REG_TIMEOUT:     tmo_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  logic [Aw-1:0] prev_slot;
  logic          scan_last;
  logic          hb, off;
  assign prev_slot = Aw'(cnt_q - Cw'(1));
  assign scan_last = (cnt_q == Cw'(MAX_PEERS));

  always_comb begin
    state_d = state_q;
    res_d = res_q;
    res_valid_d = res_valid_q;
    used_d = used_q;
    conn_d = conn_q;
    seq_d = seq_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    hit_ok_d = hit_ok_q;
    free_d = free_q;
    free_ok_d = free_ok_q;
    pend_d = pend_q;
    pend_valid_d = pend_valid_q;
    mem_we = 1'b0;
    mem_waddr = hit_q;
    mem_wdata = mem_rdata;
    mem_raddr = Aw'(cnt_q);
    hb = 1'b0;
    off = 1'b0;
    if (res_valid_q && !out_stall_i) res_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        hit_ok_d = 1'b0;
        free_ok_d = 1'b0;
        pend_valid_d = 1'b0;
        mem_raddr = '0;
        if (in_valid_i && (in_data_i.func != FUNC_NONE)) begin
          cnt_d = Cw'(1);
          state_d = ST_SCAN;
        end
      end
      // search or walk: memory data belongs to slot cnt_q-1
      ST_SCAN: begin
        if (req_q.func == FUNC_TICK) begin
          if (used_q[prev_slot]) begin
            hb = hb_en_q && reached(req_q.now_ms, mem_rdata.last_hb, hb_int_q);
            off = conn_q[prev_slot] && reached(req_q.now_ms, mem_rdata.last_seen, tmo_q);
          end
          if ((hb || off) && pend_valid_q && res_valid_q && out_stall_i) begin
            // parked word cannot leave yet: keep this slot's data
            mem_raddr = prev_slot;
          end else begin
            if (hb || off) begin
              mem_we = 1'b1;
              mem_waddr = prev_slot;
              if (hb) begin
                mem_wdata.last_hb = req_q.now_ms;
                seq_d = seq_q + 64'd1;
              end
              if (off) conn_d[prev_slot] = 1'b0;
              if (pend_valid_q) begin
                res_d = pend_q;
                res_valid_d = 1'b1;
              end
              pend_d = '0;
              pend_d.event_res = EV_TICK_ACT;
              pend_d.slot = 4'(prev_slot);
              pend_d.tracker_id = mem_rdata.tracker_id;
              pend_d.dest_ip = mem_rdata.ip;
              pend_d.dest_port = mem_rdata.port;
              pend_d.send_heartbeat = hb;
              pend_d.heartbeat_seq = hb ? seq_q : 64'd0;
              pend_d.went_offline = off;
              pend_valid_d = 1'b1;
            end
            if (scan_last) state_d = ST_OUT;
            else cnt_d = cnt_q + Cw'(1);
          end
        end else begin
          if (!hit_ok_q && used_q[prev_slot] &&
              ((req_q.func == FUNC_HANDSHAKE && mem_rdata.mac == req_q.peer_mac) ||
               (req_q.func == FUNC_DATA && mem_rdata.ip == req_q.source_ip))) begin
            hit_ok_d = 1'b1;
            hit_d = prev_slot;
          end
          if (!free_ok_q && !used_q[prev_slot]) begin
            free_ok_d = 1'b1;
            free_d = prev_slot;
          end
          if (scan_last) state_d = ST_DECIDE;
          else cnt_d = cnt_q + Cw'(1);
        end
      end
      ST_DECIDE: begin
        mem_raddr = hit_q;
        if (hit_ok_q) state_d = ST_READ;
        else if (req_q.func == FUNC_HANDSHAKE && req_q.id_available && free_ok_q) begin
          hit_d = free_q;
          state_d = ST_UPDATE;
        end else state_d = ST_OUT;
      end
      ST_READ: begin
        mem_raddr = hit_q;
        state_d = ST_UPDATE;
      end
      // update the found or claimed slot and emit its word
      ST_UPDATE: begin
        mem_raddr = hit_q;
        if (!res_valid_q || !out_stall_i) begin
          res_d = '0;
          res_d.slot = 4'(hit_q);
          res_d.last = 1'b1;
          mem_we = 1'b1;
          res_valid_d = 1'b1;
          state_d = ST_IDLE;
          if (req_q.func == FUNC_HANDSHAKE) begin
            if (!hit_ok_q) begin
              mem_wdata.tracker_id = req_q.granted_id;
              mem_wdata.mac = req_q.peer_mac;
              used_d[hit_q] = 1'b1;
              res_d.is_new = 1'b1;
            end
            mem_wdata.ip = req_q.source_ip;
            mem_wdata.port = req_q.source_port;
            mem_wdata.last_hb = req_q.now_ms;
            mem_wdata.last_seen = req_q.now_ms;
            res_d.event_res = EV_HS_OK;
            res_d.tracker_id = hit_ok_q ? mem_rdata.tracker_id : req_q.granted_id;
            res_d.dest_ip = req_q.source_ip;
            res_d.dest_port = req_q.source_port;
            res_d.send_heartbeat = 1'b1;
            res_d.heartbeat_seq = seq_q;
            res_d.went_online = !(hit_ok_q && conn_q[hit_q]);
            seq_d = seq_q + 64'd1;
            conn_d[hit_q] = 1'b1;
          end else begin
            mem_wdata.last_seen = req_q.now_ms;
            res_d.event_res = EV_DATA_OK;
            res_d.tracker_id = mem_rdata.tracker_id;
            res_d.went_online = !conn_q[hit_q];
            conn_d[hit_q] = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!res_valid_q || !out_stall_i) begin
          res_d = '0;
          res_valid_d = 1'b1;
          res_d.last = 1'b1;
          case (req_q.func)
            FUNC_HANDSHAKE: res_d.event_res = EV_FULL;
            FUNC_DATA:      res_d.event_res = EV_UNKNOWN;
            default:        res_d.event_res = EV_TICK_DONE;
          endcase
          if (req_q.func == FUNC_TICK && pend_valid_q) begin
            // flush parked tick word with last set
            res_d = pend_q;
            res_d.last = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_valid_q <= 1'b0;
      used_q <= '0;
      conn_q <= '0;
      seq_q <= '0;
      cnt_q <= '0;
      hit_ok_q <= 1'b0;
      free_ok_q <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_valid_q <= res_valid_d;
      used_q <= used_d;
      conn_q <= conn_d;
      seq_q <= seq_d;
      cnt_q <= cnt_d;
      hit_ok_q <= hit_ok_d;
      free_ok_q <= free_ok_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    hit_q <= hit_d;
    free_q <= free_d;
    pend_q <= pend_d;
    if (state_q == ST_IDLE && in_valid_i) req_q <= in_data_i;
  end

`ifndef ASSERT_OFF
  a_conn_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conn_q & ~used_q) == '0) else $error("online slot not in use");
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != $past(seq_q)) |-> (seq_q == $past(seq_q) + 64'd1))
    else $error("sequence jumped");
`endif

endmodule
`default_nettype wire
